@@ hdl/swept_aabb_collision_macros.svh @@
// Assertion macros used by the checker file.
`ifndef SWEPT_AABB_COLLISION_MACROS_SVH
`define SWEPT_AABB_COLLISION_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define SAC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication that must hold while a result is shown.
`define SAC_ASSERT_SHOWN(lbl, clk, rst, shown, prop, msg) \
   `SAC_ASSERT(lbl, clk, rst, (shown) |-> (prop), msg)

`endif

@@ hdl/sac_pkg.sv @@
// ---------------------------------------------------------------------------
// sac_pkg
// Types and constants shared by the swept box collision modules.
// ---------------------------------------------------------------------------
`default_nettype none

package sac_pkg;

   localparam int DIV_STEPS  = 17;
   localparam int DIV_LAT    = DIV_STEPS + 2;
   localparam int FIFO_DEPTH = 32;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

   localparam logic [15:0]        FRAME_TIME_RESET = 16'd4096;
   localparam logic signed [18:0] T_ONE     = 19'sd65536;
   localparam logic signed [18:0] T_CLAMP   = 19'sd65537;
   localparam logic signed [18:0] T_NEG_INF = -19'sd2;
   localparam logic signed [18:0] T_POS_INF = 19'sd65538;

   localparam logic signed [1:0] NORM_POS  = 2'sb01;
   localparam logic signed [1:0] NORM_NEG  = 2'sb11;
   localparam logic signed [1:0] NORM_NONE = 2'sb00;

   typedef struct packed {
      logic               valid;
      logic signed [24:0] gx_in;
      logic signed [24:0] gx_out;
      logic signed [24:0] gy_in;
      logic signed [24:0] gy_out;
      logic signed [33:0] dx;
      logic signed [33:0] dy;
   } front_type;

   typedef struct packed {
      logic               zero;
      logic signed [18:0] value;
   } div_out_type;

   typedef struct packed {
      logic [16:0]       entry_time;
      logic              hit;
      logic signed [1:0] normal_x;
      logic signed [1:0] normal_y;
   } result_type;

endpackage

`default_nettype wire

@@ hdl/sac_fifo.sv @@
// ---------------------------------------------------------------------------
// sac_fifo
// Result queue between the back end and the result port.
// ---------------------------------------------------------------------------
`default_nettype none

module sac_fifo import sac_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       wr_valid,
   input  wire result_type wr_data,
   input  wire logic       rd_pop,
   output result_type      rd_data,
   output logic            empty
);

   result_type           mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wptr_ff, rptr_ff;
   logic [FIFO_CW-1:0]   cnt_ff;
   logic                 do_pop;

   assign empty   = (cnt_ff == '0);
   assign do_pop  = rd_pop && !empty;
   assign rd_data = mem_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (wr_valid) begin
         mem_ff[wptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         if (wr_valid) begin
            wptr_ff <= wptr_ff + 1'b1;
         end
         if (do_pop) begin
            rptr_ff <= rptr_ff + 1'b1;
         end
         cnt_ff <= cnt_ff + FIFO_CW'(wr_valid) - FIFO_CW'(do_pop);
      end
   end

endmodule

`default_nettype wire

@@ hdl/sac_front.sv @@
// ---------------------------------------------------------------------------
// sac_front
// Takes an item, forms the facing edge gaps and the relative displacement.
// ---------------------------------------------------------------------------
`default_nettype none

module sac_front import sac_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire logic [15:0]        frame_time,
   input  wire logic signed [23:0] moving_left,
   input  wire logic signed [23:0] moving_right,
   input  wire logic signed [23:0] moving_top,
   input  wire logic signed [23:0] moving_bottom,
   input  wire logic signed [15:0] moving_vel_x,
   input  wire logic signed [15:0] moving_vel_y,
   input  wire logic signed [23:0] other_left,
   input  wire logic signed [23:0] other_right,
   input  wire logic signed [23:0] other_top,
   input  wire logic signed [23:0] other_bottom,
   input  wire logic signed [15:0] other_vel_x,
   input  wire logic signed [15:0] other_vel_y,
   output front_type               front
);

   logic signed [16:0] dvx_in, dvy_in, dvx_ff, dvy_ff;
   logic [15:0]        ft_ff;
   logic               v1_ff;
   logic signed [24:0] gxi_in, gxo_in, gyi_in, gyo_in;
   logic signed [24:0] gxi_ff, gxo_ff, gyi_ff, gyo_ff;
   logic               xpos, ypos;
   front_type          front_in, front_ff;

   function automatic logic signed [24:0] gap(input logic signed [23:0] a,
                                               input logic signed [23:0] b);
      return {a[23], a} - {b[23], b};
   endfunction

   always_comb begin
      dvx_in = {moving_vel_x[15], moving_vel_x} - {other_vel_x[15], other_vel_x};
      dvy_in = {moving_vel_y[15], moving_vel_y} - {other_vel_y[15], other_vel_y};
      // Displacement is positive when the velocity difference is and time runs.
      xpos = !dvx_in[16] && (dvx_in != '0) && (frame_time != '0);
      ypos = !dvy_in[16] && (dvy_in != '0) && (frame_time != '0);
      gxi_in = xpos ? gap(other_left, moving_right)    : gap(other_right, moving_left);
      gxo_in = xpos ? gap(other_right, moving_left)    : gap(other_left, moving_right);
      gyi_in = ypos ? gap(other_bottom, moving_top)    : gap(other_top, moving_bottom);
      gyo_in = ypos ? gap(other_top, moving_bottom)    : gap(other_bottom, moving_top);
   end

   always_comb begin
      front_in.valid  = v1_ff;
      front_in.gx_in  = gxi_ff;
      front_in.gx_out = gxo_ff;
      front_in.gy_in  = gyi_ff;
      front_in.gy_out = gyo_ff;
      front_in.dx     = dvx_ff * $signed({1'b0, ft_ff});
      front_in.dy     = dvy_ff * $signed({1'b0, ft_ff});
   end

   always_ff @(posedge clock) begin
      dvx_ff   <= dvx_in;
      dvy_ff   <= dvy_in;
      ft_ff    <= frame_time;
      gxi_ff   <= gxi_in;
      gxo_ff   <= gxo_in;
      gyi_ff   <= gyi_in;
      gyo_ff   <= gyo_in;
      if (reset) begin
         v1_ff    <= 1'b0;
         front_ff <= '0;
      end else begin
         v1_ff    <= accept;
         front_ff <= front_in;
      end
   end

   assign front = front_ff;

endmodule

`default_nettype wire

@@ hdl/sac_div.sv @@
// ---------------------------------------------------------------------------
// sac_div
// Pipelined restoring divider: (gap * 2^28) / disp, truncated, clamped, negatives as -1.
// ---------------------------------------------------------------------------
`default_nettype none

module sac_div import sac_pkg::*; (
   input  wire logic               clock,
   input  wire logic signed [24:0] gap,
   input  wire logic signed [33:0] disp,
   output div_out_type             result
);

   typedef struct packed {
      logic [32:0]          d;
      logic [32:0]          r;
      logic [DIV_STEPS-1:0] q;
      logic                 neg;
      logic                 ovf;
      logic                 zero;
   } stage_type;

   stage_type   st_ff [DIV_STEPS+1];
   stage_type   st_in [DIV_STEPS+1];
   div_out_type out_in, out_ff;
   logic [24:0] n_mag;
   logic [33:0] d_full;
   logic [35:0] hi;
   logic [33:0] r2;
   logic [17:0] mag;

   always_comb begin
      n_mag  = gap[24] ? 25'(-gap) : 25'(gap);
      d_full = disp[33] ? 34'(-disp) : 34'(disp);
      hi     = {n_mag, 11'b0};
      st_in[0].d    = d_full[32:0];
      st_in[0].r    = hi[32:0];
      st_in[0].q    = '0;
      st_in[0].neg  = gap[24] ^ disp[33];
      // The quotient cannot fit in the step count when the top part already reaches d.
      st_in[0].ovf  = (hi >= {2'b0, d_full});
      st_in[0].zero = (disp == '0);
      for (int k = 0; k < DIV_STEPS; k++) begin
         st_in[k+1] = st_ff[k];
         r2 = {st_ff[k].r, 1'b0};
         if (r2 >= {1'b0, st_ff[k].d}) begin
            st_in[k+1].r = 33'(r2 - {1'b0, st_ff[k].d});
            st_in[k+1].q = {st_ff[k].q[DIV_STEPS-2:0], 1'b1};
         end else begin
            st_in[k+1].r = r2[32:0];
            st_in[k+1].q = {st_ff[k].q[DIV_STEPS-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      mag = {1'b0, st_ff[DIV_STEPS].q};
      if (st_ff[DIV_STEPS].ovf || (mag > 18'(T_CLAMP))) begin
         mag = 18'(T_CLAMP);
      end
      out_in.zero = st_ff[DIV_STEPS].zero;
      if (st_ff[DIV_STEPS].neg && (mag != '0)) begin
         out_in.value = -19'sd1;
      end else begin
         out_in.value = $signed({1'b0, mag});
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= DIV_STEPS; k++) begin
         st_ff[k] <= st_in[k];
      end
      out_ff <= out_in;
   end

   assign result = out_ff;

endmodule

`default_nettype wire

@@ hdl/sac_back.sv @@
// ---------------------------------------------------------------------------
// sac_back
// Four axis time dividers and the final entry/exit resolution.
// ---------------------------------------------------------------------------
`default_nettype none

module sac_back import sac_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire front_type front,
   output logic           res_valid,
   output result_type     res_data
);

   typedef struct packed {
      logic valid;
      logic gx_neg;
      logic gy_neg;
   } tag_type;

   tag_type            tag_ff [DIV_LAT];
   div_out_type        qxi, qxo, qyi, qyo;
   logic signed [18:0] xin, xout, yin, yout, entry, exitt;
   logic               x_later, no_hit, res_valid_ff;
   result_type         res_in, res_ff;

   sac_div u_div_xi (.clock(clock), .gap(front.gx_in),  .disp(front.dx), .result(qxi));
   sac_div u_div_xo (.clock(clock), .gap(front.gx_out), .disp(front.dx), .result(qxo));
   sac_div u_div_yi (.clock(clock), .gap(front.gy_in),  .disp(front.dy), .result(qyi));
   sac_div u_div_yo (.clock(clock), .gap(front.gy_out), .disp(front.dy), .result(qyo));

   always_comb begin
      // A still axis enters at minus infinity and leaves at plus infinity.
      xin  = qxi.zero ? T_NEG_INF : qxi.value;
      xout = qxo.zero ? T_POS_INF : qxo.value;
      yin  = qyi.zero ? T_NEG_INF : qyi.value;
      yout = qyo.zero ? T_POS_INF : qyo.value;
      x_later = (xin > yin);
      entry   = x_later ? xin : yin;
      exitt   = (xout > yout) ? yout : xout;
      no_hit  = (entry > exitt) || (xin < 0 && yin < 0) || (xin > T_ONE) || (yin > T_ONE);
      res_in.entry_time = 17'(T_ONE);
      res_in.hit        = 1'b0;
      res_in.normal_x   = NORM_NONE;
      res_in.normal_y   = NORM_NONE;
      if (!no_hit) begin
         res_in.hit = 1'b1;
         if (entry < 0) begin
            res_in.entry_time = '0;
         end else if (entry > T_ONE) begin
            res_in.entry_time = 17'(T_ONE);
         end else begin
            res_in.entry_time = entry[16:0];
         end
         if (x_later) begin
            res_in.normal_x = tag_ff[DIV_LAT-1].gx_neg ? NORM_POS : NORM_NEG;
         end else begin
            res_in.normal_y = tag_ff[DIV_LAT-1].gy_neg ? NORM_POS : NORM_NEG;
         end
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      if (reset) begin
         for (int k = 0; k < DIV_LAT; k++) begin
            tag_ff[k] <= '0;
         end
         res_valid_ff <= 1'b0;
      end else begin
         tag_ff[0] <= '{valid: front.valid, gx_neg: front.gx_in[24], gy_neg: front.gy_in[24]};
         for (int k = 1; k < DIV_LAT; k++) begin
            tag_ff[k] <= tag_ff[k-1];
         end
         res_valid_ff <= tag_ff[DIV_LAT-1].valid;
      end
   end

   assign res_valid = res_valid_ff;
   assign res_data  = res_ff;

endmodule

`default_nettype wire

@@ hdl/swept_aabb_collision.sv @@
// ---------------------------------------------------------------------------
// swept_aabb_collision
// Swept box-against-box collision test giving contact time and face normal.
// ---------------------------------------------------------------------------
//
//   Channel   Handshake               Payload
//   req       push / full             two boxes: edges and velocities
//   rsp       empty / pop             entry_time, hit, normal_x, normal_y
//   csr       csr_valid / csr_ready   frame_time (Q4.12)
//
// One item is accepted per cycle while full is low; each result passes through
// the front stages, the pipelined dividers (one quotient bit per stage), one
// resolve stage and the write into the queue.
// Reset is synchronous and active high; it empties the pipeline and queue and
// sets frame_time to 1.0. No clearing pass is needed.
// full rises only when the 32-entry result queue plus items in flight fill it,
// so a stalled result side holds off new items without ever dropping one.
`default_nettype none

module swept_aabb_collision import sac_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   // Input items
   input  wire logic               push,
   output logic                    full,
   input  wire logic signed [23:0] req_moving_left,
   input  wire logic signed [23:0] req_moving_right,
   input  wire logic signed [23:0] req_moving_top,
   input  wire logic signed [23:0] req_moving_bottom,
   input  wire logic signed [15:0] req_moving_vel_x,
   input  wire logic signed [15:0] req_moving_vel_y,
   input  wire logic signed [23:0] req_other_left,
   input  wire logic signed [23:0] req_other_right,
   input  wire logic signed [23:0] req_other_top,
   input  wire logic signed [23:0] req_other_bottom,
   input  wire logic signed [15:0] req_other_vel_x,
   input  wire logic signed [15:0] req_other_vel_y,
   // Result items
   output logic                    empty,
   input  wire logic               pop,
   output logic [16:0]             rsp_entry_time,
   output logic                    rsp_hit,
   output logic signed [1:0]       rsp_normal_x,
   output logic signed [1:0]       rsp_normal_y,
   // Configuration
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [15:0]        csr_data
);

   logic [15:0]        frame_time_ff;
   logic [FIFO_CW-1:0] credit_ff, credit_in;
   logic               accept, popped, res_valid;
   front_type          front;
   result_type         res_data, rd_data;

   // Configuration is always taken; the user must write it only while the block idles; this is not enforced.
   assign csr_ready = 1'b1;

   // The credit count covers every item in flight plus every queued result,
   // so the queue can never overflow however long pop stays low.
   assign full      = (credit_ff == FIFO_CW'(FIFO_DEPTH));
   assign accept    = push && !full;
   assign popped    = pop && !empty;
   assign credit_in = credit_ff + FIFO_CW'(accept) - FIFO_CW'(popped);

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_time_ff <= FRAME_TIME_RESET;
         credit_ff     <= '0;
      end else begin
         if (csr_valid) begin
            frame_time_ff <= csr_data;
         end
         credit_ff <= credit_in;
      end
   end

   sac_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .frame_time    (frame_time_ff),
      .moving_left   (req_moving_left),
      .moving_right  (req_moving_right),
      .moving_top    (req_moving_top),
      .moving_bottom (req_moving_bottom),
      .moving_vel_x  (req_moving_vel_x),
      .moving_vel_y  (req_moving_vel_y),
      .other_left    (req_other_left),
      .other_right   (req_other_right),
      .other_top     (req_other_top),
      .other_bottom  (req_other_bottom),
      .other_vel_x   (req_other_vel_x),
      .other_vel_y   (req_other_vel_y),
      .front         (front)
   );

   sac_back u_back (
      .clock     (clock),
      .reset     (reset),
      .front     (front),
      .res_valid (res_valid),
      .res_data  (res_data)
   );

   sac_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (res_valid),
      .wr_data  (res_data),
      .rd_pop   (pop),
      .rd_data  (rd_data),
      .empty    (empty)
   );

   assign rsp_entry_time = rd_data.entry_time;
   assign rsp_hit        = rd_data.hit;
   assign rsp_normal_x   = rd_data.normal_x;
   assign rsp_normal_y   = rd_data.normal_y;

endmodule

`default_nettype wire

@@ hdl/sac_checker.sv @@
// ---------------------------------------------------------------------------
// sac_checker
// Checks the shape of the results shown on the result port.
// ---------------------------------------------------------------------------
`default_nettype none
`include "swept_aabb_collision_macros.svh"

module sac_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              empty,
   input wire logic [16:0]       rsp_entry_time,
   input wire logic              rsp_hit,
   input wire logic signed [1:0] rsp_normal_x,
   input wire logic signed [1:0] rsp_normal_y
);

   `SAC_ASSERT_SHOWN(a_miss_form, clock, reset, !empty && !rsp_hit, (rsp_entry_time == 17'd65536) && (rsp_normal_x == 2'sb00) && (rsp_normal_y == 2'sb00), "miss result is malformed")
   `SAC_ASSERT_SHOWN(a_hit_normal, clock, reset, !empty && rsp_hit, (rsp_normal_x == 2'sb00) != (rsp_normal_y == 2'sb00), "hit needs exactly one normal axis")
   `SAC_ASSERT_SHOWN(a_time_range, clock, reset, !empty, rsp_entry_time <= 17'd65536, "entry time out of range")
   `SAC_ASSERT_SHOWN(a_normal_code, clock, reset, !empty, (rsp_normal_x != 2'sb10) && (rsp_normal_y != 2'sb10), "illegal normal code")

endmodule

bind swept_aabb_collision sac_checker u_sac_checker (.*);

`default_nettype wire

@@ dv/tb_swept_aabb_collision.sv @@
// ---------------------------------------------------------------------------
// tb_swept_aabb_collision
// Self-checking testbench for the swept box collision block.
// Every accepted item is run through a local model of the contact-time and
// normal computation; a monitor compares each popped result with the oldest
// expectation. Directed corner cases come first, then random box pairs under
// several idling phases and several frame_time settings.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_swept_aabb_collision;
   import sac_pkg::*;

   // One pair of boxes as it travels on the request ports.
   typedef struct {
      logic signed [23:0] ml, mr, mt, mb;
      logic signed [15:0] mvx, mvy;
      logic signed [23:0] ol, orr, ot, ob;
      logic signed [15:0] ovx, ovy;
   } box_pair_t;

   // An axis time: finite Q0.16 value or one of the two infinities.
   typedef struct {
      bit         ninf;
      bit         pinf;
      longint     t;
   } axis_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic pop = 1'b0;
   logic csr_valid = 1'b0;
   logic [15:0] csr_data = '0;
   logic full, empty, csr_ready;
   logic signed [23:0] req_ml = '0, req_mr = '0, req_mt = '0, req_mb = '0;
   logic signed [23:0] req_ol = '0, req_or = '0, req_ot = '0, req_ob = '0;
   logic signed [15:0] req_mvx = '0, req_mvy = '0, req_ovx = '0, req_ovy = '0;
   logic [16:0]        rsp_entry_time;
   logic               rsp_hit;
   logic signed [1:0]  rsp_normal_x, rsp_normal_y;

   // The predictor's copy of the frame_time register.
   logic [15:0] frame_time_q = FRAME_TIME_RESET;

   result_type contact_queue[$];
   int         error_count = 0;
   int         send_idle_pct = 0;
   int         recv_stall_pct = 0;
   int         hold_cycles = 0;   // long receiver hold-off, counted down below

   always #5 clock = ~clock;

   swept_aabb_collision u_dut (
      .clock(clock), .reset(reset),
      .push(push), .full(full),
      .req_moving_left(req_ml), .req_moving_right(req_mr),
      .req_moving_top(req_mt), .req_moving_bottom(req_mb),
      .req_moving_vel_x(req_mvx), .req_moving_vel_y(req_mvy),
      .req_other_left(req_ol), .req_other_right(req_or),
      .req_other_top(req_ot), .req_other_bottom(req_ob),
      .req_other_vel_x(req_ovx), .req_other_vel_y(req_ovy),
      .empty(empty), .pop(pop),
      .rsp_entry_time(rsp_entry_time), .rsp_hit(rsp_hit),
      .rsp_normal_x(rsp_normal_x), .rsp_normal_y(rsp_normal_y),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   // Comparison of axis times where the infinities win as expected.
   function automatic bit later_than(axis_t a, axis_t b);
      if (a.ninf || b.pinf) return 1'b0;
      if (a.pinf || b.ninf) return 1'b1;
      return a.t > b.t;
   endfunction

   function automatic bit before_zero(axis_t a);
      if (a.ninf) return 1'b1;
      if (a.pinf) return 1'b0;
      return a.t < 0;
   endfunction

   function automatic bit past_frame(axis_t a);
      if (a.pinf) return 1'b1;
      if (a.ninf) return 1'b0;
      return a.t > 65536;
   endfunction

   // Entry and exit times along one axis; returns the entry gap.
   function automatic longint sweep_axis(longint lo1, longint hi1, longint lo2,
                                         longint hi2, longint disp,
                                         output axis_t t_in, output axis_t t_out);
      longint gin, gout;
      if (disp > 0) begin
         gin = lo2 - hi1;
         gout = hi2 - lo1;
      end else begin
         gin = hi2 - lo1;
         gout = lo2 - hi1;
      end
      t_in = '{0, 0, 0};
      t_out = '{0, 0, 0};
      if (disp == 0) begin
         t_in.ninf = 1'b1;
         t_out.pinf = 1'b1;
      end else begin
         // SystemVerilog division truncates toward zero; the hardware gives a nonzero negative quotient as -1.
         t_in.t = (gin * 64'sd268435456) / disp;
         t_out.t = (gout * 64'sd268435456) / disp;
      end
      return gin;
   endfunction

   function automatic result_type predict_contact(box_pair_t p);
      longint dx, dy, gx, gy, t;
      axis_t xin, xout, yin, yout, ent, ext;
      result_type r;
      dx = (longint'(p.mvx) - longint'(p.ovx)) * longint'(frame_time_q);
      dy = (longint'(p.mvy) - longint'(p.ovy)) * longint'(frame_time_q);
      gx = sweep_axis(p.ml, p.mr, p.ol, p.orr, dx, xin, xout);
      gy = sweep_axis(p.mb, p.mt, p.ob, p.ot, dy, yin, yout);
      ent = later_than(xin, yin) ? xin : yin;
      ext = later_than(xout, yout) ? yout : xout;
      r = '{entry_time: 17'd65536, hit: 1'b0, normal_x: NORM_NONE, normal_y: NORM_NONE};
      if (!(later_than(ent, ext) || (before_zero(xin) && before_zero(yin)) ||
            past_frame(xin) || past_frame(yin))) begin
         t = ent.ninf ? 0 : (ent.pinf ? 65536 : ent.t);
         if (t < 0) t = 0;
         if (t > 65536) t = 65536;
         r.entry_time = t[16:0];
         r.hit = 1'b1;
         if (later_than(xin, yin)) r.normal_x = (gx < 0) ? NORM_POS : NORM_NEG;
         else r.normal_y = (gy < 0) ? NORM_POS : NORM_NEG;
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   // Sends one box pair, with a random gap first when the sender idles.
   // push stays high on return so that the next item can follow at once;
   // whoever stops sending lowers it.
   task automatic send_pair(box_pair_t p);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_ml <= p.ml;   req_mr <= p.mr;   req_mt <= p.mt;   req_mb <= p.mb;
      req_mvx <= p.mvx; req_mvy <= p.mvy;
      req_ol <= p.ol;   req_or <= p.orr;  req_ot <= p.ot;   req_ob <= p.ob;
      req_ovx <= p.ovx; req_ovy <= p.ovy;
      @(posedge clock);
      while (full) @(posedge clock);
      contact_queue.push_back(predict_contact(p));
   endtask

   task automatic write_frame_time(logic [15:0] value);
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      frame_time_q = value;
   endtask

   // Stops sending, waits for every expectation to drain, then lets the
   // pipeline settle.
   task automatic drain_results();
      push <= 1'b0;
      while (contact_queue.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   // Receiver: random stalls, plus the long hold-off when one is requested.
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         pop <= 1'b0;
      end else begin
         pop <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Result monitor: compares every popped item with the oldest expectation.
   always @(posedge clock) begin
      result_type want;
      if (!reset && pop && !empty) begin
         if (contact_queue.size() == 0) begin
            report_mismatch("unexpected result", rsp_entry_time, -1);
         end else begin
            want = contact_queue.pop_front();
            if (rsp_entry_time !== want.entry_time)
               report_mismatch("entry_time", rsp_entry_time, want.entry_time);
            if (rsp_hit !== want.hit)
               report_mismatch("hit", rsp_hit, want.hit);
            if (rsp_normal_x !== want.normal_x)
               report_mismatch("normal_x", rsp_normal_x, want.normal_x);
            if (rsp_normal_y !== want.normal_y)
               report_mismatch("normal_y", rsp_normal_y, want.normal_y);
         end
      end
   end

   function automatic logic signed [23:0] rand_edge();
      case ($urandom_range(3))
         0: return 24'($urandom());
         1: return 24'sh800000 + 24'($urandom_range(3)) * 24'sh7FFFFF;
         default: return 24'($signed(16'($urandom())));
      endcase
   endfunction

   function automatic logic signed [15:0] rand_vel();
      if ($urandom_range(5) == 0) return '0;
      return 16'($urandom());
   endfunction

   // Mostly a well-formed pair: ordered edges near each other, so hits are common.
   function automatic box_pair_t rand_pair();
      box_pair_t p;
      int span;
      if ($urandom_range(9) == 0) begin
         p = '{rand_edge(), rand_edge(), rand_edge(), rand_edge(), rand_vel(),
               rand_vel(), rand_edge(), rand_edge(), rand_edge(), rand_edge(),
               rand_vel(), rand_vel()};
         return p;
      end
      span = $urandom_range(1, 4) * 4096;
      p.ml = 24'($signed(24'($urandom_range(0, 2 * span))) - span);
      p.mr = 24'(p.ml + $urandom_range(1, span));
      p.mb = 24'($signed(24'($urandom_range(0, 2 * span))) - span);
      p.mt = 24'(p.mb + $urandom_range(1, span));
      p.ol = 24'($signed(24'($urandom_range(0, 2 * span))) - span);
      p.orr = 24'(p.ol + $urandom_range(1, span));
      p.ob = 24'($signed(24'($urandom_range(0, 2 * span))) - span);
      p.ot = 24'(p.ob + $urandom_range(1, span));
      p.mvx = rand_vel(); p.mvy = rand_vel();
      p.ovx = rand_vel(); p.ovy = rand_vel();
      return p;
   endfunction

   // Edge values, still axes, head-on approaches and misses at the default rate.
   task automatic test_directed();
      box_pair_t p;
      p = '{0, 256, 256, 0, 16'sh1000, 0, 1024, 1280, 256, 0, 0, 0};
      send_pair(p);                                   // x hit, y still
      p = '{0, 256, 256, 0, 0, -16'sh1000, 0, 256, -512, -768, 0, 0};
      send_pair(p);                                   // y hit from above
      p = '{0, 256, 256, 0, 0, 0, 1024, 1280, 256, 0, 0, 0};
      send_pair(p);                                   // both still
      p = '{0, 256, 256, 0, -16'sh1000, 0, 1024, 1280, 256, 0, 0, 0};
      send_pair(p);                                   // moving away
      p = '{0, 256, 256, 0, 16'sh0001, 16'sh0001, 24'sh7FFFFF, 24'sh7FFFFF,
            24'sh7FFFFF, 24'sh7FFFFF, 0, 0};
      send_pair(p);                                   // far too far
      p = '{0, 256, 256, 0, 16'sh1000, 16'sh1000, 100, 400, 300, 100, 0, 0};
      send_pair(p);                                   // already overlapping
      p = '{24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 16'sh7FFF,
            16'sh7FFF, 24'sh7FFFFF, 24'sh800000, 24'sh800000, 24'sh7FFFFF,
            16'sh8000, 16'sh8000};
      send_pair(p);
      p = '{24'sh7FFFFF, 24'sh800000, 24'sh800000, 24'sh7FFFFF, 16'sh8000,
            16'sh8000, 24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000,
            16'sh7FFF, 16'sh7FFF};
      send_pair(p);
      p = '{0, 256, 256, 0, 16'sh1000, 16'sh1000, 512, 768, 768, 512, 0, 0};
      send_pair(p);                                   // equal entries, y normal
      p = '{0, 256, 256, 0, -16'sh0800, 16'sh0800, -768, -512, 768, 512, 0, 0};
      send_pair(p);
      p = '{-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1};
      send_pair(p);
      p = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
      send_pair(p);
      drain_results();
   endtask

   task automatic test_random(int count);
      repeat (count) send_pair(rand_pair());
   endtask

   // Idling phases: none, sender only, receiver only, both.
   task automatic test_idle_phases();
      send_idle_pct = 0;  recv_stall_pct = 0;  test_random(60);
      send_idle_pct = 48; recv_stall_pct = 0;  test_random(50);
      send_idle_pct = 0;  recv_stall_pct = 48; test_random(50);
      send_idle_pct = 30; recv_stall_pct = 30; test_random(50);
      send_idle_pct = 0;  recv_stall_pct = 0;
      drain_results();
   endtask

   // The receiver holds off long enough for the queue to fill and full to rise.
   task automatic test_backpressure();
      hold_cycles <= 200;
      test_random(60);
      drain_results();
   endtask

   // Frame times at both ends and a few between, including zero.
   task automatic test_frame_times();
      logic [15:0] settings[6] = '{16'd0, 16'hFFFF, 16'd1, 16'd256, 16'd37, 16'd4096};
      foreach (settings[i]) begin
         write_frame_time(settings[i]);
         recv_stall_pct = (i % 2) ? 30 : 0;
         send_idle_pct = (i % 3 == 0) ? 30 : 0;
         test_random(25);
         drain_results();
      end
      send_idle_pct = 0;
      recv_stall_pct = 0;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_idle_phases();
      test_backpressure();
      test_frame_times();
      if (contact_queue.size() != 0) error_count++;
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

`default_nettype wire

@@ sim.f @@
+incdir+hdl
hdl/sac_pkg.sv
hdl/sac_fifo.sv
hdl/sac_front.sv
hdl/sac_div.sv
hdl/sac_back.sv
hdl/swept_aabb_collision.sv
hdl/sac_checker.sv
dv/tb_swept_aabb_collision.sv
